// ----- rtl/crcs_pkg.sv -----
package crcs_pkg;

  // Samples per segment are 2**STEPS_LOG2 + 1 (t = k/STEPS, k = 0..STEPS).
  localparam int STEPS_LOG2 = 4;
  localparam int STEPS      = 1 << STEPS_LOG2;
  localparam int K_W        = STEPS_LOG2 + 1;
  localparam int S_CUBE     = 1 << (3 * STEPS_LOG2);

  // Field and register widths.
  localparam int COORD_W   = 32;
  localparam int TENSION_W = 15;
  localparam int ANI_W     = 31;
  localparam int CFG_W     = 31;
  localparam int CFG_IDX_W = 1;

  // Datapath widths (basis coefficients, weight numerators, weights, products, sums) and the rounding shift.
  localparam int COEF_W     = 18;
  localparam int N_W        = 3 * STEPS_LOG2 + COEF_W + 2;
  localparam int WGT_W      = N_W + 15 - 3 * STEPS_LOG2;
  localparam int PROD_W     = WGT_W + COORD_W;
  localparam int SUM_W      = PROD_W + 2;
  localparam int FRAC_SHIFT = 28;

  // Q4.14 unity and its multiples used by the basis matrix.
  localparam logic signed [COEF_W-1:0] Q_ONE   = COEF_W'(16384);
  localparam logic signed [COEF_W-1:0] Q_TWO   = COEF_W'(32768);
  localparam logic signed [COEF_W-1:0] Q_THREE = COEF_W'(49152);

  // Register reset values.
  localparam logic [TENSION_W-1:0] TENSION_RST = 15'd8192;
  localparam logic [ANI_W-1:0]     ANI_RST     = 31'd1310720;

  // Register indexes.
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_IDX_TENSION = 1'b0;
  localparam cfg_idx_t CFG_IDX_ANI     = 1'b1;

  // Input item: one control point.
  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic                      final_point;
  } point_t;

  // Result item: one curve sample.
  typedef struct packed {
    logic signed [COORD_W-1:0] curve_x;
    logic signed [COORD_W-1:0] curve_y;
    logic                      run_end;
  } sample_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic seed;
    logic append;
    logic shift;
    logic load_main;
    logic load_trail;
    logic seg_end;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic gen_valid;
    logic gen_end;
    logic adv;
  } dp_status_t;

endpackage

// ----- rtl/crcs_ctrl.sv -----
module crcs_ctrl import crcs_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_final,
  input  dp_status_t stat,
  output logic       in_stall,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SWEEP = 3'b010,
    ST_LOADT = 3'b100
  } state_t;

  // Window fill levels that occur: empty, two points, three points.
  localparam logic [1:0] HELD_EMPTY = 2'd0;
  localparam logic [1:0] HELD_TWO   = 2'd2;
  localparam logic [1:0] HELD_THREE = 2'd3;

  state_t     state_r, state_nxt;
  logic [1:0] held_r, held_nxt;
  logic       trail_pend_r, trail_pend_nxt;
  logic       accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  // Next state and datapath commands.
  always_comb begin
    state_nxt      = state_r;
    held_nxt       = held_r;
    trail_pend_nxt = trail_pend_r;
    cmd            = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (held_r == HELD_EMPTY) begin
            cmd.seed = 1'b1;
            held_nxt = in_final ? HELD_EMPTY : HELD_TWO;
          end else if (held_r == HELD_THREE) begin
            cmd.shift      = 1'b1;
            cmd.load_main  = 1'b1;
            cmd.seg_end    = !in_final;
            held_nxt       = in_final ? HELD_EMPTY : HELD_THREE;
            trail_pend_nxt = in_final;
            state_nxt      = ST_SWEEP;
          end else begin
            cmd.append = 1'b1;
            held_nxt   = in_final ? HELD_EMPTY : HELD_THREE;
            if (in_final) begin
              state_nxt = ST_LOADT;
            end
          end
        end
      end
      ST_SWEEP: begin
        if (stat.gen_end && stat.adv) begin
          if (trail_pend_r) begin
            cmd.load_trail = 1'b1;
            cmd.seg_end    = 1'b1;
            trail_pend_nxt = 1'b0;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_LOADT: begin
        cmd.load_trail = 1'b1;
        cmd.seg_end    = 1'b1;
        state_nxt      = ST_SWEEP;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      held_r       <= HELD_EMPTY;
      trail_pend_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      held_r       <= held_nxt;
      trail_pend_r <= trail_pend_nxt;
    end
  end

endmodule

// ----- rtl/crcs_dp.sv -----
module crcs_dp import crcs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  cfg_idx_t           cfg_index,
  input  logic [CFG_W-1:0]   cfg_wdata,
  input  point_t             in_data,
  input  ctrl_cmd_t          cmd,
  output dp_status_t         stat,
  output logic               out_valid,
  input  logic               out_stall,
  output sample_t            out_data
);

  localparam logic signed [SUM_W-1:0] SAT_MAX = SUM_W'(2147483647);
  localparam logic signed [SUM_W-1:0] SAT_MIN = ~SAT_MAX;

  // Round a Q.44 accumulation to Q16.16 and clamp to 32 bits.
  function automatic logic signed [COORD_W-1:0] round_sat(
    input logic signed [SUM_W-1:0] s
  );
    logic signed [SUM_W-1:0] r;
    begin
      r = (s + (SUM_W'(1) <<< (FRAC_SHIFT - 1))) >>> FRAC_SHIFT;
      if (r > SAT_MAX) begin
        round_sat = SAT_MAX[COORD_W-1:0];
      end else if (r < SAT_MIN) begin
        round_sat = SAT_MIN[COORD_W-1:0];
      end else begin
        round_sat = r[COORD_W-1:0];
      end
    end
  endfunction

  logic [TENSION_W-1:0] tension_r;
  logic [ANI_W-1:0]     ani_r;

  logic signed [COORD_W-1:0] win_x_r [3];
  logic signed [COORD_W-1:0] win_y_r [3];
  logic signed [COORD_W-1:0] trail_y_r;

  logic signed [COEF_W-1:0] a;
  logic signed [COEF_W-1:0] r0 [4];
  logic signed [COEF_W-1:0] r1 [4];
  logic signed [COEF_W-1:0] r2 [4];
  logic signed [COEF_W-1:0] r3 [4];
  logic signed [N_W-1:0]    ca [4];
  logic signed [N_W-1:0]    cb [4];
  logic signed [N_W-1:0]    cc [4];
  logic signed [N_W-1:0]    n0 [4];
  logic signed [N_W-1:0]    d1_init [4];
  logic signed [N_W-1:0]    d2_init [4];
  logic signed [N_W-1:0]    d3 [4];

  logic signed [N_W-1:0]     n_r  [4];
  logic signed [N_W-1:0]     d1_r [4];
  logic signed [N_W-1:0]     d2_r [4];
  logic signed [COORD_W-1:0] seg_x_r [4];
  logic signed [COORD_W-1:0] seg_y_r [4];
  logic [K_W-1:0]            k_r;
  logic                      g_valid_r;
  logic                      seg_end_r;

  logic signed [N_W+15:0]  wtmp [4];
  logic signed [WGT_W-1:0] wgt  [4];

  logic signed [PROD_W-1:0] px_r [4];
  logic signed [PROD_W-1:0] py_r [4];
  logic                     p_valid_r;
  logic                     p_last_r;

  logic signed [SUM_W-1:0] qx_r [2];
  logic signed [SUM_W-1:0] qy_r [2];
  logic                    q_valid_r;
  logic                    q_last_r;

  logic signed [SUM_W-1:0] tot_x, tot_y;
  logic                    out_valid_r;
  sample_t                 out_data_r;

  logic adv;
  logic g_end;
  logic load;

  assign adv   = !(out_valid_r && out_stall);
  assign g_end = g_valid_r && (k_r == K_W'(STEPS));
  assign load  = cmd.load_main || cmd.load_trail;

  assign stat.gen_valid = g_valid_r;
  assign stat.gen_end   = g_end;
  assign stat.adv       = adv;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tension_r <= TENSION_RST;
      ani_r     <= ANI_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_TENSION: tension_r <= cfg_wdata[TENSION_W-1:0];
        CFG_IDX_ANI:     ani_r     <= cfg_wdata[ANI_W-1:0];
      endcase
    end
  end

  // Point window: seeded with the leading pad, appended, or shifted by one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 3; i++) begin
        win_x_r[i] <= '0;
        win_y_r[i] <= '0;
      end
      trail_y_r <= '0;
    end else begin
      if (cmd.seed) begin
        win_x_r[0] <= '0;
        win_y_r[0] <= in_data.point_y;
        win_x_r[1] <= in_data.point_x;
        win_y_r[1] <= in_data.point_y;
      end
      if (cmd.append) begin
        win_x_r[2] <= in_data.point_x;
        win_y_r[2] <= in_data.point_y;
      end
      if (cmd.shift) begin
        win_x_r[0] <= win_x_r[1];
        win_y_r[0] <= win_y_r[1];
        win_x_r[1] <= win_x_r[2];
        win_y_r[1] <= win_y_r[2];
        win_x_r[2] <= in_data.point_x;
        win_y_r[2] <= in_data.point_y;
      end
      if (cmd.seed || cmd.append || cmd.shift) begin
        trail_y_r <= in_data.point_y;
      end
    end
  end

  // Basis matrix from the tension, and the forward difference seeds of
  // each weight numerator n(k) = R0*k^3 + S*R1*k^2 + S^2*R2*k + S^3*R3.
  always_comb begin
    a = {{(COEF_W - TENSION_W){1'b0}}, tension_r};
    r0[0] = -a;               r0[1] = Q_TWO - a;       r0[2] = a - Q_TWO;  r0[3] = a;
    r1[0] = a <<< 1;          r1[1] = a - Q_THREE;     r1[2] = Q_THREE - (a <<< 1);
    r1[3] = -a;
    r2[0] = -a;               r2[1] = '0;              r2[2] = a;          r2[3] = '0;
    r3[0] = '0;               r3[1] = Q_ONE;           r3[2] = '0;         r3[3] = '0;
    for (int j = 0; j < 4; j++) begin
      ca[j]      = N_W'(r0[j]);
      cb[j]      = N_W'(r1[j]) <<< STEPS_LOG2;
      cc[j]      = N_W'(r2[j]) <<< (2 * STEPS_LOG2);
      n0[j]      = N_W'(r3[j]) <<< (3 * STEPS_LOG2);
      d1_init[j] = ca[j] + cb[j] + cc[j];
      d2_init[j] = (ca[j] <<< 2) + (ca[j] <<< 1) + (cb[j] <<< 1);
      d3[j]      = (ca[j] <<< 2) + (ca[j] <<< 1);
    end
  end

  // Sample generator control: one sample per advancing cycle.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      g_valid_r <= 1'b0;
      k_r       <= '0;
    end else if (load) begin
      g_valid_r <= 1'b1;
      k_r       <= '0;
    end else if (adv && g_valid_r) begin
      if (g_end) begin
        g_valid_r <= 1'b0;
      end else begin
        k_r <= k_r + K_W'(1);
      end
    end
  end

  // Sample generator data: segment points and the difference engine.
  always_ff @(posedge clk) begin
    if (load) begin
      for (int j = 0; j < 3; j++) begin
        seg_x_r[j] <= win_x_r[j];
        seg_y_r[j] <= win_y_r[j];
      end
      if (cmd.load_main) begin
        seg_x_r[3] <= in_data.point_x;
        seg_y_r[3] <= in_data.point_y;
      end else begin
        seg_x_r[3] <= {1'b0, ani_r};
        seg_y_r[3] <= trail_y_r;
      end
      for (int j = 0; j < 4; j++) begin
        n_r[j]  <= n0[j];
        d1_r[j] <= d1_init[j];
        d2_r[j] <= d2_init[j];
      end
      seg_end_r <= cmd.seg_end;
    end else if (adv && g_valid_r && !g_end) begin
      for (int j = 0; j < 4; j++) begin
        n_r[j]  <= n_r[j] + d1_r[j];
        d1_r[j] <= d1_r[j] + d2_r[j];
        d2_r[j] <= d2_r[j] + d3[j];
      end
    end
  end

  // Weights in Q.28: n * 2^14 / S^3, rounded half up.
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      wtmp[j] = ((N_W + 16)'(n_r[j]) <<< 15) + (N_W + 16)'(S_CUBE);
      wgt[j]  = WGT_W'(wtmp[j] >>> (3 * STEPS_LOG2 + 1));
    end
  end

  // Pipeline valid flags.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r   <= 1'b0;
      q_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r   <= g_valid_r;
      q_valid_r   <= p_valid_r;
      out_valid_r <= q_valid_r;
    end
  end

  // Product stage, pair sum stage, then round and clamp into the output register.
  always_comb begin
    tot_x = qx_r[0] + qx_r[1];
    tot_y = qy_r[0] + qy_r[1];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int j = 0; j < 4; j++) begin
        px_r[j] <= wgt[j] * seg_x_r[j];
        py_r[j] <= wgt[j] * seg_y_r[j];
      end
      p_last_r <= g_end && seg_end_r;

      qx_r[0]  <= SUM_W'(px_r[0]) + SUM_W'(px_r[1]);
      qx_r[1]  <= SUM_W'(px_r[2]) + SUM_W'(px_r[3]);
      qy_r[0]  <= SUM_W'(py_r[0]) + SUM_W'(py_r[1]);
      qy_r[1]  <= SUM_W'(py_r[2]) + SUM_W'(py_r[3]);
      q_last_r <= p_last_r;

      out_data_r.curve_x <= round_sat(tot_x);
      out_data_r.curve_y <= round_sat(tot_y);
      out_data_r.run_end <= q_last_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- rtl/catmull_rom_curve_sampler.sv -----
// Channel   Direction  Handshake            Payload
// cfg       in         cfg_we               cfg_index, cfg_wdata
// in        in         in_valid / in_stall  in_data (point_t)
// out       out        out_valid / out_stall out_data (sample_t)
//
// A point that completes a window of four is taken as it loads the sample generator, which
// then issues the STEPS+1 = 17 samples, one per cycle while the pipeline advances. A final
// point adds a trailing segment, loaded as the main one ends; a final point that only
// completes three is appended, then the trailing one is loaded. Points that only fill the
// window raise no stall. Samples pass product, pair sum and output registers to out_valid.
// Reset is synchronous, active low; out_stall with out_valid high freezes the sample pipeline.
module catmull_rom_curve_sampler import crcs_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  cfg_idx_t         cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata,
  input  logic             in_valid,
  output logic             in_stall,
  input  point_t           in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output sample_t          out_data
);

  ctrl_cmd_t  cmd;
  dp_status_t stat;

  crcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_final (in_data.final_point),
    .stat     (stat),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  crcs_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // A segment is loaded only into an empty generator or as the previous one ends.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_main || cmd.load_trail) |-> (!stat.gen_valid || (stat.gen_end && stat.adv)))
    else $error("segment loaded over a busy sample generator");

  // A new point is taken only once the generator has issued every sample.
  a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |-> !stat.gen_valid)
    else $error("point accepted while samples are still being issued");

  // The main and trailing segments never load together.
  a_one_load: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.load_main && cmd.load_trail))
    else $error("main and trailing segment loaded together");

endmodule
